[rtl/gra_pkg.sv]
// Shared types and constants for the guillotine rectangle allocator.
package gra_pkg;

  localparam int FIELD_W     = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int STATUS_W    = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_BIN_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BIN_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROTATE_EN  = 2'd2;

  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_PLACE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic found;
    logic rot;
  } fit_flags_t;

endpackage

[rtl/guillotine_rect_allocator.sv]
// Top level: guillotine rectangle allocator with a scanning sequencer.
//
//  channel | ports                           | contents
//  in      | in_tvalid/in_tready/in_tdata/   | tuser: action; tdata: req_width, req_height
//          | in_tuser                        |
//  out     | out_tvalid/out_tready/out_tdata/| tuser: status; tdata: pos_x, pos_y, rotated
//          | out_tuser                       |
//  cfg     | cfg_we/cfg_addr/cfg_wdata       | bin_width, bin_height, rotate_enable
//
// A placed transaction runs from accept to accept as one pass of the
// shared fit unit over the free list through the single read port, a decision state, the
// move, right and bottom write states on the single write port and the result state. A
// refused place skips the writes. A clear goes straight from the accept to the result state.
// One transaction is in flight at a time; in_tready is low until the result is taken.
// Reset empties the free list; the store itself needs no clearing pass.
module guillotine_rect_allocator
  import gra_pkg::*;
#(
  parameter int FREE_ENTRIES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // req_width, req_height
  input  logic                   in_tuser,   // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pos_x, pos_y, rotated, zero pad
  output logic [STATUS_W-1:0]    out_tuser   // status
);

  localparam int CB    = COORD_BITS;
  localparam int DW    = 4 * CB;
  localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_WMOVE  = 3'd3;
  localparam logic [2:0] S_WRIGHT = 3'd4;
  localparam logic [2:0] S_WBOT   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                ent_vld_r, ent_vld_nxt;
  logic [IDX_W-1:0]    ent_idx_r;
  logic [CB-1:0]       bin_w_r, bin_h_r;
  logic                rot_en_r;
  logic [FIELD_W-1:0]  req_w_r, req_h_r;

  logic [STATUS_W-1:0] status_r;
  logic [CB-1:0]       pos_x_r, pos_y_r;
  logic                rotated_r;
  logic [IDX_W-1:0]    idx_r;
  logic                split_r_r, split_b_r;
  logic [DW-1:0]       right_r, bot_r;

  logic                in_acc, fit_clr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [DW-1:0]       mem_wdata, mem_rdata;

  fit_flags_t          sel_flags;
  logic [IDX_W-1:0]    sel_idx;
  logic [DW-1:0]       sel_rect;

  logic [CB-1:0]       fx, fy, fw, fh;
  logic [FIELD_W-1:0]  pw, ph, fw16, fh16, rx_sum, by_sum;
  logic                sp_rgt, sp_bot, full;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fit_clr   = in_acc;

  gra_free_mem #(
    .DEPTH (FREE_ENTRIES),
    .DW    (DW),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gra_fit_unit #(
    .CB    (CB),
    .IDX_W (IDX_W)
  ) u_fit (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (fit_clr),
    .ent_vld   (ent_vld_r),
    .ent_idx   (ent_idx_r),
    .ent_rect  (mem_rdata),
    .req_w     (req_w_r),
    .req_h     (req_h_r),
    .rot_en    (rot_en_r),
    .sel_flags (sel_flags),
    .sel_idx   (sel_idx),
    .sel_rect  (sel_rect)
  );

  assign fx     = sel_rect[CB-1:0];
  assign fy     = sel_rect[2*CB-1:CB];
  assign fw     = sel_rect[3*CB-1:2*CB];
  assign fh     = sel_rect[4*CB-1:3*CB];
  assign fw16   = FIELD_W'(fw);
  assign fh16   = FIELD_W'(fh);
  assign pw     = sel_flags.rot ? req_h_r : req_w_r;
  assign ph     = sel_flags.rot ? req_w_r : req_h_r;
  assign sp_rgt = fw16 > pw;
  assign sp_bot = fh16 > ph;
  assign full   = (count_r == CNT_W'(FREE_ENTRIES)) && sp_rgt && sp_bot;
  assign rx_sum = FIELD_W'(fx) + pw;
  assign by_sum = FIELD_W'(fy) + ph;

  always_comb begin
    mem_raddr = scan_r[IDX_W-1:0];
    if (state_r == S_DECIDE) begin
      mem_raddr = IDX_W'(count_r - CNT_W'(1));
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[IDX_W-1:0];
    mem_wdata = right_r;
    case (state_r)
      S_IDLE: begin
        mem_we    = in_acc && (in_tuser == ACT_CLEAR);
        mem_waddr = '0;
        mem_wdata = {bin_h_r, bin_w_r, {(2*CB){1'b0}}};
      end
      S_WMOVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
      end
      S_WRIGHT: begin
        mem_we    = split_r_r;
        mem_wdata = right_r;
      end
      S_WBOT: begin
        mem_we    = split_b_r;
        mem_wdata = bot_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    ent_vld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          scan_nxt = '0;
          if (in_tuser == ACT_CLEAR) begin
            count_nxt = CNT_W'(1);
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_r < count_r) begin
          ent_vld_nxt = 1'b1;
          scan_nxt    = scan_r + CNT_W'(1);
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = (sel_flags.found && !full) ? S_WMOVE : S_OUT;
      end
      S_WMOVE: begin
        count_nxt = count_r - CNT_W'(1);
        state_nxt = S_WRIGHT;
      end
      S_WRIGHT: begin
        if (split_r_r) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = S_WBOT;
      end
      S_WBOT: begin
        if (split_b_r) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      scan_r    <= '0;
      ent_vld_r <= 1'b0;
      bin_w_r   <= '0;
      bin_h_r   <= '0;
      rot_en_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      scan_r    <= scan_nxt;
      ent_vld_r <= ent_vld_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BIN_WIDTH:  bin_w_r  <= cfg_wdata[CB-1:0];
          CFG_BIN_HEIGHT: bin_h_r  <= cfg_wdata[CB-1:0];
          CFG_ROTATE_EN:  rot_en_r <= cfg_wdata[0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_idx_r <= scan_r[IDX_W-1:0];
    if (in_acc) begin
      req_w_r   <= in_tdata[FIELD_W-1:0];
      req_h_r   <= in_tdata[2*FIELD_W-1:FIELD_W];
      status_r  <= ST_OK;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      rotated_r <= 1'b0;
    end
    if (state_r == S_DECIDE) begin
      idx_r     <= sel_idx;
      split_r_r <= sp_rgt;
      split_b_r <= sp_bot;
      right_r   <= {fh, fw - pw[CB-1:0], fy, rx_sum[CB-1:0]};
      bot_r     <= {fh - ph[CB-1:0], pw[CB-1:0], by_sum[CB-1:0], fx};
      if (!sel_flags.found) begin
        status_r <= ST_NOFIT;
      end else if (full) begin
        status_r <= ST_FULL;
      end else begin
        status_r  <= ST_OK;
        pos_x_r   <= fx;
        pos_y_r   <= fy;
        rotated_r <= sel_flags.rot;
      end
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = status_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*FIELD_W - 1){1'b0}}, rotated_r,
                       FIELD_W'(pos_y_r), FIELD_W'(pos_x_r)};

endmodule

[rtl/gra_free_mem.sv]
// Free rectangle store: one write port, one registered read port.
module gra_free_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/gra_fit_unit.sv]
// Shared fit compare unit: tracks the best unrotated and rotated fit over a scan.
module gra_fit_unit
  import gra_pkg::*;
#(
  parameter int CB    = 16,
  parameter int IDX_W = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 ent_vld,
  input  logic [IDX_W-1:0]     ent_idx,
  input  logic [4*CB-1:0]      ent_rect,
  input  logic [FIELD_W-1:0]   req_w,
  input  logic [FIELD_W-1:0]   req_h,
  input  logic                 rot_en,
  output fit_flags_t           sel_flags,
  output logic [IDX_W-1:0]     sel_idx,
  output logic [4*CB-1:0]      sel_rect
);

  logic [CB-1:0]      ex, ey;
  logic [FIELD_W-1:0] ew16, eh16;
  logic               fit0, fit1, better0, better1;

  logic               f0_r, f1_r;
  logic [IDX_W-1:0]   i0_r, i1_r;
  logic [4*CB-1:0]    r0_r, r1_r;
  logic [CB-1:0]      x0, y0, x1, y1;
  logic               rot;

  assign ex   = ent_rect[CB-1:0];
  assign ey   = ent_rect[2*CB-1:CB];
  assign ew16 = FIELD_W'(ent_rect[3*CB-1:2*CB]);
  assign eh16 = FIELD_W'(ent_rect[4*CB-1:3*CB]);

  assign x0 = r0_r[CB-1:0];
  assign y0 = r0_r[2*CB-1:CB];
  assign x1 = r1_r[CB-1:0];
  assign y1 = r1_r[2*CB-1:CB];

  assign fit0    = (ew16 >= req_w) && (eh16 >= req_h);
  assign fit1    = rot_en && (ew16 >= req_h) && (eh16 >= req_w);
  assign better0 = !f0_r || (ey < y0) || ((ey == y0) && (ex < x0));
  assign better1 = !f1_r || (ey < y1) || ((ey == y1) && (ex < x1));

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      f0_r <= 1'b0;
      f1_r <= 1'b0;
    end else if (ent_vld) begin
      if (fit0 && better0) begin
        f0_r <= 1'b1;
      end
      if (fit1 && better1) begin
        f1_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ent_vld && fit0 && better0) begin
      i0_r <= ent_idx;
      r0_r <= ent_rect;
    end
    if (ent_vld && fit1 && better1) begin
      i1_r <= ent_idx;
      r1_r <= ent_rect;
    end
  end

  always_comb begin
    if (!f0_r) begin
      rot = 1'b1;
    end else if (f1_r) begin
      rot = (y1 < y0) || ((y1 == y0) && (x1 < x0)) ||
            ((y1 == y0) && (x1 == x0) && (i1_r < i0_r));
    end else begin
      rot = 1'b0;
    end
  end

  assign sel_flags.found = f0_r || f1_r;
  assign sel_flags.rot   = rot;
  assign sel_idx         = rot ? i1_r : i0_r;
  assign sel_rect        = rot ? r1_r : r0_r;

endmodule

[rtl/gra_checker.sv]
// Port-level checker for the guillotine rectangle allocator, with its bind.
module gra_checker
  import gra_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]    out_tuser
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a transaction");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NOFIT || out_tuser == ST_FULL))
    else $error("undefined status code");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == '0))
    else $error("refused result carries a position");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind guillotine_rect_allocator gra_checker u_gra_checker (.*);
